// ----- hw/rtl/sprite_quad_vertex_emit_assert.svh -----
// Assertion macros for the checker file.
`ifndef SPRITE_QUAD_VERTEX_EMIT_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_EMIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SQV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqv assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SQV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqv assertion failed");

`endif

// ----- hw/rtl/sqv_pkg.sv -----
package sqv_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    // Angle datapath in Q.30 radians
    localparam int ANG_W = 37;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 37'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 37'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 37'sd1686629713;

    // CORDIC vector width and start value (gain compensated, Q.30)
    localparam int CS_W = 34;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_INDICES = 6;

    // Record kinds
    localparam logic RES_VERTEX = 1'b0;
    localparam logic RES_INDEX  = 1'b1;

    // Arctangent of 2^-i in Q.30
    function automatic logic [29:0] f_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Vertex offset of each triangle index within the quad
    function automatic logic [1:0] f_tri_ofs(input logic [2:0] n);
        logic [1:0] v;
        case (n)
            3'd0:    v = 2'd0;
            3'd1:    v = 2'd1;
            3'd2:    v = 2'd2;
            3'd3:    v = 2'd0;
            3'd4:    v = 2'd2;
            3'd5:    v = 2'd3;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

    // Q1.8 tint channel to 8 bits: floor(t*255/256), clipped at 255
    function automatic logic [7:0] f_chan8(input logic [8:0] t);
        logic [16:0] p;
        p = 17'(t) * 17'd255;
        return p[16] ? 8'hFF : p[15:8];
    endfunction

endpackage

// ----- hw/rtl/sqv_stream_if.sv -----
interface sqv_in_if;
    logic               valid;
    logic               ready;
    logic               frame_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] quad_size;
    logic signed [20:0] rot_angle;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [31:0] tex_u0;
    logic signed [31:0] tex_u1;
    logic signed [31:0] tex_v0;
    logic signed [31:0] tex_v1;
    logic        [35:0] tint_rgba;

    modport source (
        output valid, frame_start, pos_x, pos_y, quad_size, rot_angle, scale_x, scale_y,
               tex_u0, tex_u1, tex_v0, tex_v1, tint_rgba,
        input  ready
    );
    modport sink (
        input  valid, frame_start, pos_x, pos_y, quad_size, rot_angle, scale_x, scale_y,
               tex_u0, tex_u1, tex_v0, tex_v1, tint_rgba,
        output ready
    );
endinterface

interface sqv_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_u;
    logic signed [31:0] vert_v;
    logic        [31:0] color_rgba;
    logic        [31:0] index_value;
    logic               last;

    modport source (
        output valid, result_kind, vert_x, vert_y, vert_u, vert_v, color_rgba,
               index_value, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, vert_x, vert_y, vert_u, vert_v, color_rgba,
               index_value, last,
        output ready
    );
endinterface

// ----- hw/rtl/sqv_mul.sv -----
module sqv_mul #(
    parameter int A_W = 41,
    parameter int B_W = 28
) (
    input  logic                     i_clk,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    // Register the full signed product
    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/sqv_cordic.sv -----
module sqv_cordic import sqv_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    localparam int CW          = FRAC_BITS + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [20:0]   i_angle,
    output logic                 o_done,
    output logic signed [CW-1:0] o_cos,
    output logic signed [CW-1:0] o_sin
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int IW = $clog2(CORDIC_STEPS);
    localparam logic signed [CS_W-1:0] RND = CS_W'(1) <<< (SH - 1);

    typedef enum logic [2:0] {CS_IDLE, CS_RED, CS_FOLD, CS_ROT, CS_FIN} t_cs_state;

    t_cs_state               r_state;
    logic signed [ANG_W-1:0] r_r;
    logic signed [CS_W-1:0]  r_x;
    logic signed [CS_W-1:0]  r_y;
    logic                    r_neg;
    logic [IW-1:0]           r_i;
    logic signed [CW-1:0]    r_cos;
    logic signed [CW-1:0]    r_sin;
    logic                    r_done;

    logic signed [CS_W-1:0]  w_x_sh;
    logic signed [CS_W-1:0]  w_y_sh;
    logic signed [ANG_W-1:0] w_atan;
    logic signed [CS_W-1:0]  w_xr;
    logic signed [CS_W-1:0]  w_yr;

    // Shared shift/add unit operands
    assign w_x_sh = r_x >>> r_i;
    assign w_y_sh = r_y >>> r_i;
    assign w_atan = ANG_W'(f_atan(5'(r_i)));
    assign w_xr   = (r_x + RND) >>> SH;
    assign w_yr   = (r_y + RND) >>> SH;

    // Reduce, fold, rotate, round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
            r_neg   <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= (r_state == CS_FIN);
            case (r_state)
                CS_IDLE: begin
                    if (i_start) begin
                        r_r     <= ANG_W'(i_angle) <<< 14;
                        r_state <= CS_RED;
                    end
                end
                CS_RED: begin
                    if (r_r < 0) begin
                        r_r <= r_r + ANG_TWO_PI;
                    end else if (r_r >= ANG_TWO_PI) begin
                        r_r <= r_r - ANG_TWO_PI;
                    end else begin
                        if (r_r > ANG_PI) begin
                            r_r <= r_r - ANG_TWO_PI;
                        end
                        r_state <= CS_FOLD;
                    end
                end
                CS_FOLD: begin
                    if (r_r > ANG_HALF_PI) begin
                        r_r   <= r_r - ANG_PI;
                        r_neg <= 1'b1;
                    end else if (r_r < -ANG_HALF_PI) begin
                        r_r   <= r_r + ANG_PI;
                        r_neg <= 1'b1;
                    end else begin
                        r_neg <= 1'b0;
                    end
                    r_x     <= CORDIC_GAIN;
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= CS_ROT;
                end
                CS_ROT: begin
                    if (r_r >= 0) begin
                        r_x <= r_x - w_y_sh;
                        r_y <= r_y + w_x_sh;
                        r_r <= r_r - w_atan;
                    end else begin
                        r_x <= r_x + w_y_sh;
                        r_y <= r_y - w_x_sh;
                        r_r <= r_r + w_atan;
                    end
                    if (r_i == IW'(CORDIC_STEPS - 1)) begin
                        r_state <= CS_FIN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                CS_FIN: begin
                    r_cos   <= r_neg ? CW'(-w_xr) : CW'(w_xr);
                    r_sin   <= r_neg ? CW'(-w_yr) : CW'(w_yr);
                    r_state <= CS_IDLE;
                end
                default: r_state <= CS_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// ----- hw/rtl/sprite_quad_vertex_emit.sv -----
// Sprite quad vertex emitter: takes one sprite word and returns ten output words, the four
// corners counter-clockwise (kind 0) and then six triangle indices (kind 1, last on the
// tenth) against a running vertex base that frame_start clears. One sprite at a time: the
// input is not ready from acceptance until the tenth word is loaded into the output
// register. A sprite runs through acceptance, up to four angle reduction steps plus one
// fold, CORDIC_STEPS rotations on the shared shift/add unit with a start, a round and a
// handoff around the rotations, then eighteen products on the single shared multiplier,
// each a multiply and an accumulate step, a setup step per corner and one emit step per
// word, each emit waiting while the output register still holds an untaken word.
module sprite_quad_vertex_emit import sqv_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sqv_in_if.sink     i_in,
    sqv_out_if.source  o_out
);

    localparam int CW   = FRAC_BITS + 3;
    localparam int B_W  = (CW > 24) ? CW : 24;
    localparam int A_W  = 41;
    localparam int P_W  = A_W + B_W;
    localparam int SC_W = 58;
    localparam int ACW  = P_W - FRAC_BITS + 2;

    localparam logic signed [P_W-1:0]  TRND = P_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SC_W-1:0] SRND = SC_W'(65536);
    localparam logic signed [ACW-1:0]  SMAX = (ACW'(1) <<< 31) - ACW'(1);
    localparam logic signed [ACW-1:0]  SMIN = -SMAX - ACW'(1);

    typedef enum logic [2:0] {ST_IDLE, ST_CS, ST_SXY, ST_MUL, ST_ACC, ST_EMIT} t_state;

    function automatic logic signed [31:0] f_sat(input logic signed [ACW-1:0] v);
        if (v > SMAX) return 32'sh7FFFFFFF;
        if (v < SMIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    t_state               r_state;
    logic                 r_pre;
    logic                 r_tri;
    logic [2:0]           r_k;
    logic [1:0]           r_j;
    logic                 r_cs_start;
    logic [31:0]          r_base;

    logic signed [31:0]   r_pos_x;
    logic signed [31:0]   r_pos_y;
    logic [31:0]          r_half;
    logic signed [20:0]   r_angle;
    logic signed [23:0]   r_scx;
    logic signed [23:0]   r_scy;
    logic signed [31:0]   r_u0;
    logic signed [31:0]   r_u1;
    logic signed [31:0]   r_v0;
    logic signed [31:0]   r_v1;
    logic [35:0]          r_tint;
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;
    logic signed [SC_W-1:0] r_px;
    logic signed [SC_W-1:0] r_py;
    logic signed [A_W-1:0]  r_sx;
    logic signed [A_W-1:0]  r_sy;
    logic signed [ACW-1:0]  r_ax;
    logic signed [ACW-1:0]  r_ay;

    logic                 r_out_valid;
    logic                 r_out_kind;
    logic signed [31:0]   r_out_x;
    logic signed [31:0]   r_out_y;
    logic signed [31:0]   r_out_u;
    logic signed [31:0]   r_out_v;
    logic [31:0]          r_out_color;
    logic [31:0]          r_out_index;
    logic                 r_out_last;

    logic                 w_cs_done;
    logic signed [CW-1:0] w_cos;
    logic signed [CW-1:0] w_sin;
    logic signed [A_W-1:0] w_a;
    logic signed [B_W-1:0] w_b;
    logic signed [P_W-1:0] w_prod;
    logic signed [P_W-1:0] w_rnd_sum;
    logic signed [ACW-1:0] w_term;
    logic                 w_negx;
    logic                 w_negy;
    logic signed [SC_W-1:0] w_px_s;
    logic signed [SC_W-1:0] w_py_s;
    logic signed [SC_W-1:0] w_sx_full;
    logic signed [SC_W-1:0] w_sy_full;
    logic [31:0]          w_color;
    logic                 w_out_free;
    logic                 w_emit;

    sqv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cs_start),
        .i_angle (r_angle),
        .o_done  (w_cs_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    sqv_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // Select multiplier operands: two scale products, then four terms per corner
    always_comb begin
        w_a = r_sx;
        w_b = B_W'(r_cos);
        if (r_pre) begin
            w_a = A_W'(signed'({1'b0, r_half}));
            w_b = r_j[0] ? B_W'(r_scy) : B_W'(r_scx);
        end else begin
            case (r_j)
                2'd0:    begin w_a = r_sx; w_b = B_W'(r_cos); end
                2'd1:    begin w_a = r_sy; w_b = B_W'(r_sin); end
                2'd2:    begin w_a = r_sx; w_b = B_W'(r_sin); end
                2'd3:    begin w_a = r_sy; w_b = B_W'(r_cos); end
                default: begin w_a = r_sx; w_b = B_W'(r_cos); end
            endcase
        end
    end

    // Round each term half up to Q.16
    assign w_rnd_sum = w_prod + TRND;
    assign w_term    = ACW'(w_rnd_sum >>> FRAC_BITS);

    // Corner half-offsets: left/bottom corners take the negated product
    assign w_negx    = (r_k == 3'd0) || (r_k == 3'd3);
    assign w_negy    = !r_k[1];
    assign w_px_s    = w_negx ? -r_px : r_px;
    assign w_py_s    = w_negy ? -r_py : r_py;
    assign w_sx_full = (w_px_s + SRND) >>> 17;
    assign w_sy_full = (w_py_s + SRND) >>> 17;

    assign w_color = {f_chan8(r_tint[35:27]), f_chan8(r_tint[26:18]),
                      f_chan8(r_tint[17:9]), f_chan8(r_tint[8:0])};

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pre       <= 1'b0;
            r_tri       <= 1'b0;
            r_k         <= '0;
            r_j         <= '0;
            r_cs_start  <= 1'b0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cs_start <= (r_state == ST_IDLE) && i_in.valid;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_pos_x <= i_in.pos_x;
                        r_pos_y <= i_in.pos_y;
                        r_half  <= i_in.quad_size;
                        r_angle <= i_in.rot_angle;
                        r_scx   <= i_in.scale_x;
                        r_scy   <= i_in.scale_y;
                        r_u0    <= i_in.tex_u0;
                        r_u1    <= i_in.tex_u1;
                        r_v0    <= i_in.tex_v0;
                        r_v1    <= i_in.tex_v1;
                        r_tint  <= i_in.tint_rgba;
                        if (i_in.frame_start) begin
                            r_base <= '0;
                        end
                        r_tri      <= 1'b0;
                        r_state    <= ST_CS;
                    end
                end
                ST_CS: begin
                    if (w_cs_done) begin
                        r_cos   <= w_cos;
                        r_sin   <= w_sin;
                        r_pre   <= 1'b1;
                        r_j     <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_SXY: begin
                    r_sx    <= A_W'(w_sx_full);
                    r_sy    <= A_W'(w_sy_full);
                    r_ax    <= ACW'(r_pos_x);
                    r_ay    <= ACW'(r_pos_y);
                    r_j     <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_pre) begin
                        if (r_j == 2'd0) begin
                            r_px    <= SC_W'(w_prod);
                            r_j     <= 2'd1;
                            r_state <= ST_MUL;
                        end else begin
                            r_py    <= SC_W'(w_prod);
                            r_pre   <= 1'b0;
                            r_k     <= '0;
                            r_state <= ST_SXY;
                        end
                    end else begin
                        case (r_j)
                            2'd0:    r_ax <= r_ax + w_term;
                            2'd1:    r_ax <= r_ax - w_term;
                            2'd2:    r_ay <= r_ay + w_term;
                            2'd3:    r_ay <= r_ay + w_term;
                            default: r_ax <= r_ax;
                        endcase
                        if (r_j == 2'd3) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        if (!r_tri) begin
                            // Drive one corner word
                            r_out_kind  <= RES_VERTEX;
                            r_out_x     <= f_sat(r_ax);
                            r_out_y     <= f_sat(r_ay);
                            r_out_u     <= w_negx ? r_u0 : r_u1;
                            r_out_v     <= w_negy ? r_v0 : r_v1;
                            r_out_color <= w_color;
                            r_out_index <= r_base + 32'(r_k);
                            r_out_last  <= 1'b0;
                            if (r_k == 3'(NUM_CORNERS - 1)) begin
                                r_tri <= 1'b1;
                                r_k   <= '0;
                            end else begin
                                r_k     <= r_k + 3'd1;
                                r_state <= ST_SXY;
                            end
                        end else begin
                            // Drive one triangle index word
                            r_out_kind  <= RES_INDEX;
                            r_out_x     <= '0;
                            r_out_y     <= '0;
                            r_out_u     <= '0;
                            r_out_v     <= '0;
                            r_out_color <= '0;
                            r_out_index <= r_base + 32'(f_tri_ofs(r_k));
                            r_out_last  <= (r_k == 3'(NUM_INDICES - 1));
                            if (r_k == 3'(NUM_INDICES - 1)) begin
                                r_base  <= r_base + 32'(NUM_CORNERS);
                                r_tri   <= 1'b0;
                                r_k     <= '0;
                                r_state <= ST_IDLE;
                            end else begin
                                r_k <= r_k + 3'd1;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.vert_x      = r_out_x;
    assign o_out.vert_y      = r_out_y;
    assign o_out.vert_u      = r_out_u;
    assign o_out.vert_v      = r_out_v;
    assign o_out.color_rgba  = r_out_color;
    assign o_out.index_value = r_out_index;
    assign o_out.last        = r_out_last;

endmodule

// ----- hw/rtl/sqv_checker.sv -----
`include "sprite_quad_vertex_emit_assert.svh"

module sqv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic        i_out_last,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_y,
    input logic [31:0] i_out_color
);

    // Busy right after taking a sprite
    `SQV_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // Only an index word closes a sprite
    `SQV_ASSERT_IMP(a_last_is_index, i_clk, i_rst_n, i_out_valid && i_out_last, i_out_kind)
    // Index words carry no position or color
    `SQV_ASSERT_IMP(a_index_zero, i_clk, i_rst_n, i_out_valid && i_out_kind, i_out_x == 32'd0 && i_out_y == 32'd0 && i_out_color == 32'd0)
    // Hold a stalled output word
    `SQV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind sprite_quad_vertex_emit sqv_checker u_sqv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_last  (o_out.last),
    .i_out_x     (o_out.vert_x),
    .i_out_y     (o_out.vert_y),
    .i_out_color (o_out.color_rgba)
);

// ----- tb/sv/tb_sprite_quad_vertex_emit.sv -----
`timescale 1ns / 1ps

module tb_sprite_quad_vertex_emit;
    import sqv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        frame_start;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] quad_size;
        logic [20:0] rot_angle;
        logic [23:0] scale_x;
        logic [23:0] scale_y;
        logic [31:0] tex_u0;
        logic [31:0] tex_u1;
        logic [31:0] tex_v0;
        logic [31:0] tex_v1;
        logic [35:0] tint_rgba;
    } t_sprite;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [31:0] vert_u;
        logic [31:0] vert_v;
        logic [31:0] color_rgba;
        logic [31:0] index_value;
        logic        last;
    } t_vertex_word;

    logic i_clk;
    logic i_rst_n;

    sqv_in_if  sprite_bus ();
    sqv_out_if vertex_bus ();

    sprite_quad_vertex_emit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sprite_bus.sink),
        .o_out   (vertex_bus.source)
    );

    t_vertex_word expected_words[$];
    logic [31:0]  model_base;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_off_cycles;
    event         hold_off_kick;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Angle to cosine and sine in Q1.16
    task automatic calc_cos_sin(input logic signed [20:0] ang,
                                output longint c, output longint s);
        longint r, x, y, nx;
        longint atan_tab[16];
        bit     flip;
        atan_tab = '{843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                     131071, 65535, 32767};
        flip = 1'b0;
        r = (longint'(ang) * 16384) % 64'sd6746518852;
        if (r < 0) r += 64'sd6746518852;
        if (r > 64'sd3373259426) r -= 64'sd6746518852;
        if (r > 64'sd1686629713) begin
            r -= 64'sd3373259426;
            flip = 1'b1;
        end else if (r < -64'sd1686629713) begin
            r += 64'sd3373259426;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r += atan_tab[i];
            end
            x = nx;
        end
        x = (x + 64'sd8192) >>> 14;
        y = (y + 64'sd8192) >>> 14;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint round_q16(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [31:0] clamp_s32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [7:0] tint_to_byte(logic [8:0] t);
        int p;
        p = (int'(t) * 255) >> 8;
        return (p > 255) ? 8'hFF : p[7:0];
    endfunction

    // Build the ten words of one sprite and advance the vertex base
    task automatic predict_quad(input t_sprite sp);
        longint       c, s, half, sx, sy, px, py;
        int           sgn_x[4];
        int           sgn_y[4];
        int           tri_ofs[6];
        logic [31:0]  color;
        t_vertex_word w;
        sgn_x   = '{-1, 1, 1, -1};
        sgn_y   = '{-1, -1, 1, 1};
        tri_ofs = '{0, 1, 2, 0, 2, 3};
        if (sp.frame_start) model_base = '0;
        calc_cos_sin(sp.rot_angle, c, s);
        half  = longint'(sp.quad_size);
        px    = longint'(signed'(sp.pos_x));
        py    = longint'(signed'(sp.pos_y));
        color = {tint_to_byte(sp.tint_rgba[35:27]), tint_to_byte(sp.tint_rgba[26:18]),
                 tint_to_byte(sp.tint_rgba[17:9]), tint_to_byte(sp.tint_rgba[8:0])};
        for (int k = 0; k < 4; k++) begin
            sx = (sgn_x[k] * half * longint'(signed'(sp.scale_x)) + 65536) >>> 17;
            sy = (sgn_y[k] * half * longint'(signed'(sp.scale_y)) + 65536) >>> 17;
            w.result_kind = RES_VERTEX;
            w.vert_x      = clamp_s32(px + round_q16(sx, c) - round_q16(sy, s));
            w.vert_y      = clamp_s32(py + round_q16(sx, s) + round_q16(sy, c));
            w.vert_u      = (k == 0 || k == 3) ? sp.tex_u0 : sp.tex_u1;
            w.vert_v      = (k < 2) ? sp.tex_v0 : sp.tex_v1;
            w.color_rgba  = color;
            w.index_value = model_base + 32'(k);
            w.last        = 1'b0;
            expected_words = {expected_words, w};
        end
        for (int k = 0; k < 6; k++) begin
            w             = '{default: '0};
            w.result_kind = RES_INDEX;
            w.index_value = model_base + 32'(tri_ofs[k]);
            w.last        = (k == 5);
            expected_words = {expected_words, w};
        end
        model_base += 32'd4;
    endtask

    function automatic t_sprite random_sprite(bit wild);
        t_sprite sp;
        sp.frame_start = ($urandom_range(0, 15) == 0);
        sp.pos_x       = $urandom;
        sp.pos_y       = $urandom;
        sp.rot_angle   = 21'($urandom);
        sp.tex_u0      = $urandom;
        sp.tex_u1      = $urandom;
        sp.tex_v0      = $urandom;
        sp.tex_v1      = $urandom;
        sp.tint_rgba   = 36'({$urandom, $urandom});
        if (wild) begin
            sp.quad_size = $urandom;
            sp.scale_x   = 24'($urandom);
            sp.scale_y   = 24'($urandom);
        end else begin
            // Keep most quads on screen so corners stay off the rails
            sp.pos_x     = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            sp.pos_y     = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            sp.quad_size = $urandom_range(0, 32'h00FF_FFFF);
            sp.scale_x   = 24'($signed($urandom_range(0, 24'h07_FFFF)) - 24'sh04_0000);
            sp.scale_y   = 24'($signed($urandom_range(0, 24'h07_FFFF)) - 24'sh04_0000);
        end
        return sp;
    endfunction

    // Offer one sprite word and hold it until accepted
    task automatic send_sprite(input t_sprite sp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sprite_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sprite_bus.valid       <= 1'b1;
        sprite_bus.frame_start <= sp.frame_start;
        sprite_bus.pos_x       <= sp.pos_x;
        sprite_bus.pos_y       <= sp.pos_y;
        sprite_bus.quad_size   <= sp.quad_size;
        sprite_bus.rot_angle   <= sp.rot_angle;
        sprite_bus.scale_x     <= sp.scale_x;
        sprite_bus.scale_y     <= sp.scale_y;
        sprite_bus.tex_u0      <= sp.tex_u0;
        sprite_bus.tex_u1      <= sp.tex_u1;
        sprite_bus.tex_v0      <= sp.tex_v0;
        sprite_bus.tex_v1      <= sp.tex_v1;
        sprite_bus.tint_rgba   <= sp.tint_rgba;
        @(posedge i_clk);
        while (!sprite_bus.ready) @(posedge i_clk);
        predict_quad(sp);
    endtask

    // Drop the input and wait for every predicted word
    task automatic wait_drained();
        sprite_bus.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_sprite sp;
        logic [20:0] angles[8];
        angles = '{21'h0, 21'h1921F, 21'h3243F, 21'h0FFFFF, 21'h100000, 21'h1FFFFF,
                   21'h1CDE1, 21'h6487E};
        for (int i = 0; i < 8; i++) begin
            sp = '{default: '0};
            sp.frame_start = (i == 0);
            sp.quad_size   = 32'h0040_0000;
            sp.scale_x     = 24'h01_0000;
            sp.scale_y     = 24'h01_8000;
            sp.rot_angle   = angles[i];
            sp.tex_u0      = 32'h0000_0000;
            sp.tex_u1      = 32'h0001_0000;
            sp.tex_v0      = 32'h8000_0000;
            sp.tex_v1      = 32'h7FFF_FFFF;
            sp.tint_rgba   = {9'd256, 9'd0, 9'd511, 9'd255};
            send_sprite(sp);
        end
        // Extremes: saturating positions, full size and scale
        sp = '{default: '1};
        sp.pos_x = 32'h7FFF_FFFF; sp.pos_y = 32'h7FFF_FFFF;
        sp.scale_x = 24'h7F_FFFF; sp.scale_y = 24'h7F_FFFF;
        send_sprite(sp);
        sp.pos_x = 32'h8000_0000; sp.pos_y = 32'h8000_0000;
        sp.scale_x = 24'h80_0000; sp.scale_y = 24'h80_0000;
        sp.frame_start = 1'b0; sp.tint_rgba = '0;
        send_sprite(sp);
        sp = '{default: '0};
        send_sprite(sp);
        sp.scale_x = 24'hFF_0000; sp.scale_y = 24'h00_0001; sp.quad_size = 32'h1;
        sp.rot_angle = 21'h10_0001;
        send_sprite(sp);
        wait_drained();
    endtask

    // Restart the base with frame_start and run a short pack after it
    task automatic test_base_wrap();
        t_sprite sp;
        sp = random_sprite(1'b0);
        sp.frame_start = 1'b1;
        send_sprite(sp);
        for (int i = 0; i < 6; i++) begin
            sp = random_sprite(1'b0);
            sp.frame_start = 1'b0;
            send_sprite(sp);
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int n, input int snd, input int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < n; i++) send_sprite(random_sprite($urandom_range(0, 3) == 0));
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the output off long while sprites keep coming, then drain fully
    task automatic test_back_pressure();
        -> hold_off_kick;
        for (int i = 0; i < 6; i++) send_sprite(random_sprite(1'b0));
        wait_drained();
        repeat (100) @(posedge i_clk);
        for (int i = 0; i < 4; i++) send_sprite(random_sprite(1'b0));
        wait_drained();
    endtask

    // Count down a long receiver hold-off on request
    initial begin
        hold_off_cycles = 0;
        forever begin
            @(hold_off_kick);
            hold_off_cycles = 400;
            while (hold_off_cycles > 0) begin
                @(posedge i_clk);
                hold_off_cycles <= hold_off_cycles - 1;
            end
        end
    end

    // Output ready generation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vertex_bus.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            vertex_bus.ready <= 1'b0;
        end else begin
            vertex_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each accepted output word with the oldest prediction
    always @(posedge i_clk) begin
        t_vertex_word exp_w;
        t_vertex_word got;
        if (i_rst_n && vertex_bus.valid && vertex_bus.ready) begin
            got = '{vertex_bus.result_kind, vertex_bus.vert_x, vertex_bus.vert_y,
                    vertex_bus.vert_u, vertex_bus.vert_v, vertex_bus.color_rgba,
                    vertex_bus.index_value, vertex_bus.last};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word kind=%0d idx=%h", $time, got.result_kind,
                         got.index_value);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w) begin
                    $display("%0t: mismatch expected kind=%0d x=%h y=%h u=%h v=%h c=%h i=%h l=%0d",
                             $time, exp_w.result_kind, exp_w.vert_x, exp_w.vert_y,
                             exp_w.vert_u, exp_w.vert_v, exp_w.color_rgba,
                             exp_w.index_value, exp_w.last);
                    $display("%0t: mismatch actual   kind=%0d x=%h y=%h u=%h v=%h c=%h i=%h l=%0d",
                             $time, got.result_kind, got.vert_x, got.vert_y, got.vert_u,
                             got.vert_v, got.color_rgba, got.index_value, got.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((sprite_bus.valid && sprite_bus.ready) || (vertex_bus.valid && vertex_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        model_base      = '0;
        i_rst_n         = 1'b0;
        sprite_bus.valid       = 1'b0;
        sprite_bus.frame_start = 1'b0;
        sprite_bus.pos_x       = '0;
        sprite_bus.pos_y       = '0;
        sprite_bus.quad_size   = '0;
        sprite_bus.rot_angle   = '0;
        sprite_bus.scale_x     = '0;
        sprite_bus.scale_y     = '0;
        sprite_bus.tex_u0      = '0;
        sprite_bus.tex_u1      = '0;
        sprite_bus.tex_v0      = '0;
        sprite_bus.tex_v1      = '0;
        sprite_bus.tint_rgba   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_base_wrap();
        test_random_phase(120, 0, 0);
        test_random_phase(100, 82, 0);
        test_random_phase(100, 0, 82);
        test_random_phase(110, 31, 31);
        test_back_pressure();

        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
